/* rtl/core/texel_format_to_rgba8_top_assert.svh */
// Assertion macros shared by the RTL; they expect clk and rst in scope.
`ifndef TEXEL_FORMAT_TO_RGBA8_TOP_ASSERT_SVH
`define TEXEL_FORMAT_TO_RGBA8_TOP_ASSERT_SVH

// Same-cycle implication.
`define TFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tfr_pkg.sv */
package tfr_pkg;

  localparam logic [1:0] KIND_CONVERT    = 2'd0;
  localparam logic [1:0] KIND_WRITE      = 2'd1;
  localparam logic [1:0] KIND_INVALIDATE = 2'd2;

  localparam logic [3:0] FMT_RGB332   = 4'd0;
  localparam logic [3:0] FMT_A8       = 4'd1;
  localparam logic [3:0] FMT_I8       = 4'd2;
  localparam logic [3:0] FMT_AI44     = 4'd3;
  localparam logic [3:0] FMT_P8       = 4'd4;
  localparam logic [3:0] FMT_ARGB8332 = 4'd5;
  localparam logic [3:0] FMT_RGB565   = 4'd6;
  localparam logic [3:0] FMT_ARGB1555 = 4'd7;
  localparam logic [3:0] FMT_ARGB4444 = 4'd8;
  localparam logic [3:0] FMT_AI88     = 4'd9;
  localparam logic [3:0] FMT_AP88     = 4'd10;

  localparam logic [23:0] MAGENTA_RGB = 24'hFF00FF;

  typedef struct packed {
    logic        rd_en;
    logic [7:0]  rd_idx;
    logic        wr_en;
    logic [7:0]  wr_idx;
    logic [23:0] wr_data;
    logic        clear;
  } pal_req_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

endpackage

/* rtl/core/tfr_palette.sv */
module tfr_palette #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  tfr_pkg::pal_req_t req,
  output logic [23:0]      color
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0] ENTRIES = 9'(PALETTE_ENTRIES);
  localparam logic [7:0] LAST_IDX = 8'(PALETTE_ENTRIES - 1);

  logic [23:0]                mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] written;
  logic                       pal_ready;
  logic [23:0]                rd_data;
  logic                       rd_hit;
  logic                       rd_ready;
  logic                       wr_ok;
  logic                       rd_in_range;

  assign wr_ok       = req.wr_en && ({1'b0, req.wr_idx} < ENTRIES);
  assign rd_in_range = {1'b0, req.rd_idx} < ENTRIES;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[req.wr_idx[IDX_W-1:0]] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_idx[IDX_W-1:0]];
    end
  end

  // Entries never written read as zero through their written bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      pal_ready <= 1'b0;
      rd_hit    <= 1'b0;
      rd_ready  <= 1'b0;
    end else begin
      if (wr_ok) begin
        written[req.wr_idx[IDX_W-1:0]] <= 1'b1;
        if (req.wr_idx == LAST_IDX) begin
          pal_ready <= 1'b1;
        end
      end
      if (req.clear) begin
        pal_ready <= 1'b0;
      end
      if (req.rd_en) begin
        rd_ready <= pal_ready;
        rd_hit   <= rd_in_range && written[req.rd_idx[IDX_W-1:0]];
      end
    end
  end

  assign color = !rd_ready ? tfr_pkg::MAGENTA_RGB : (rd_hit ? rd_data : 24'h000000);

`include "texel_format_to_rgba8_top_assert.svh"

  `TFR_ASSERT_NEXT(a_last_sets_ready, wr_ok && req.wr_idx == LAST_IDX, pal_ready, "last entry write did not set ready")
  `TFR_ASSERT_NEXT(a_clear_drops_ready, req.clear, !pal_ready, "invalidate did not clear ready")
  `TFR_ASSERT_NEXT(a_unready_magenta, req.rd_en && !pal_ready, color == tfr_pkg::MAGENTA_RGB, "lookup before ready not magenta")

endmodule

/* rtl/core/tfr_expand.sv */
module tfr_expand (
  input  logic [3:0]      texel_format,
  input  logic [15:0]     texel,
  input  logic [23:0]     pal_color,
  output tfr_pkg::rgba_t  rgba
);

  // floor(x*255/7) = 36x + floor(3x/7)
  function automatic logic [7:0] exp3(input logic [2:0] x);
    logic [4:0] x3;
    logic [1:0] q;
    x3 = 5'(x) * 5'd3;
    q = {1'b0, x3 >= 5'd7} + {1'b0, x3 >= 5'd14} + {1'b0, x3 >= 5'd21};
    return {5'b0, x} * 8'd36 + {6'b0, q};
  endfunction

  // floor(x*255/31) = 8x + floor(7x/31)
  function automatic logic [7:0] exp5(input logic [4:0] x);
    logic [7:0] x7;
    logic [2:0] q;
    x7 = 8'(x) * 8'd7;
    q = 3'd0;
    for (int k = 1; k < 8; k++) begin
      q = q + {2'b0, x7 >= 8'(31 * k)};
    end
    return {x, 3'b000} + {5'b0, q};
  endfunction

  // floor(x*255/63) = 4x + floor(x/21)
  function automatic logic [7:0] exp6(input logic [5:0] x);
    logic [1:0] q;
    q = {1'b0, x >= 6'd21} + {1'b0, x >= 6'd42} + {1'b0, x >= 6'd63};
    return {x, 2'b00} + {6'b0, q};
  endfunction

  logic [7:0] lo;
  logic [7:0] hi;

  assign lo = texel[7:0];
  assign hi = texel[15:8];

  always_comb begin
    rgba = '{r: 8'hFF, g: 8'h00, b: 8'hFF, a: 8'hFF};
    case (texel_format)
      tfr_pkg::FMT_RGB332: begin
        rgba = '{r: exp3(lo[7:5]), g: exp3(lo[4:2]), b: {4{lo[1:0]}}, a: 8'hFF};
      end
      tfr_pkg::FMT_A8: begin
        rgba = '{r: 8'hFF, g: 8'hFF, b: 8'hFF, a: lo};
      end
      tfr_pkg::FMT_I8: begin
        rgba = '{r: lo, g: lo, b: lo, a: 8'hFF};
      end
      tfr_pkg::FMT_AI44: begin
        rgba = '{r: {2{lo[3:0]}}, g: {2{lo[3:0]}}, b: {2{lo[3:0]}}, a: {2{lo[7:4]}}};
      end
      tfr_pkg::FMT_P8: begin
        rgba = '{r: pal_color[23:16], g: pal_color[15:8], b: pal_color[7:0], a: 8'hFF};
      end
      tfr_pkg::FMT_ARGB8332: begin
        rgba = '{r: exp3(lo[7:5]), g: exp3(lo[4:2]), b: {4{lo[1:0]}}, a: hi};
      end
      tfr_pkg::FMT_RGB565: begin
        rgba = '{r: exp5(texel[15:11]), g: exp6(texel[10:5]), b: exp5(texel[4:0]),
                 a: 8'hFF};
      end
      tfr_pkg::FMT_ARGB1555: begin
        rgba = '{r: exp5(texel[14:10]), g: exp5(texel[9:5]), b: exp5(texel[4:0]),
                 a: {8{texel[15]}}};
      end
      tfr_pkg::FMT_ARGB4444: begin
        rgba = '{r: {2{texel[11:8]}}, g: {2{texel[7:4]}}, b: {2{texel[3:0]}},
                 a: {2{texel[15:12]}}};
      end
      tfr_pkg::FMT_AI88: begin
        rgba = '{r: lo, g: lo, b: lo, a: hi};
      end
      tfr_pkg::FMT_AP88: begin
        rgba = '{r: pal_color[23:16], g: pal_color[15:8], b: pal_color[7:0], a: hi};
      end
      default: begin
        rgba = '{r: 8'hFF, g: 8'h00, b: 8'hFF, a: 8'hFF};
      end
    endcase
  end

endmodule

/* rtl/core/texel_format_to_rgba8_top.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_ready  | kind, texel_format, texel, palette_index,
//          |                      | palette_value
// output   | out_valid / out_ready| red, green, blue, alpha
//
// One request per clock while the output is not stalled. A convert request
// passes through the stage register, with the palette read, and then the output
// register. Palette writes and invalidates take effect at acceptance and give no
// result. Reset clears the palette valid bits and the ready flag at once, so no
// clearing pass is needed. A stalled output holds the stage register and then
// the input; no request is dropped.
module texel_format_to_rgba8_top #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  texel_format,
  input  logic [15:0] texel,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha
);

  tfr_pkg::pal_req_t pal_req;
  tfr_pkg::rgba_t    rgba;
  logic [23:0]       pal_color;

  logic        accept;
  logic        accept_conv;
  logic        out_free;
  logic        advance;
  logic        s1_valid;
  logic [3:0]  s1_fmt;
  logic [15:0] s1_texel;

  assign out_free    = !out_valid || out_ready;
  assign advance     = s1_valid && out_free;
  assign in_ready    = !s1_valid || out_free;
  assign accept      = in_valid && in_ready;
  assign accept_conv = accept && (kind == tfr_pkg::KIND_CONVERT);

  always_comb begin
    pal_req.rd_en   = accept_conv;
    pal_req.rd_idx  = texel[7:0];
    pal_req.wr_en   = accept && (kind == tfr_pkg::KIND_WRITE);
    pal_req.wr_idx  = palette_index;
    pal_req.wr_data = palette_value;
    pal_req.clear   = accept && (kind == tfr_pkg::KIND_INVALIDATE);
  end

  tfr_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .rst   (rst),
    .req   (pal_req),
    .color (pal_color)
  );

  tfr_expand u_expand (
    .texel_format (s1_fmt),
    .texel        (s1_texel),
    .pal_color    (pal_color),
    .rgba         (rgba)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept_conv) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_conv) begin
      s1_fmt   <= texel_format;
      s1_texel <= texel;
    end
    if (advance) begin
      red   <= rgba.r;
      green <= rgba.g;
      blue  <= rgba.b;
      alpha <= rgba.a;
    end
  end

`include "texel_format_to_rgba8_top_assert.svh"

  `TFR_ASSERT_NEXT(a_advance_loads_out, advance, out_valid, "stage advance lost its result")
  `TFR_ASSERT_NEXT(a_no_result_for_ctrl, accept && kind != tfr_pkg::KIND_CONVERT, s1_valid == ($past(s1_valid) && !$past(advance)), "palette request produced a result")
  `TFR_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid && $stable({red, green, blue, alpha}), "result changed while stalled")

endmodule

/* tb/sv/texel_format_to_rgba8_top_test.sv */
`timescale 1ns / 100ps

module texel_format_to_rgba8_top_test;

  localparam int PAL_ENTRIES = 256;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 900;
  localparam int LONG_HOLD = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fmt;
    logic [15:0] texel;
    logic [7:0]  pidx;
    logic [23:0] pval;
  } request_t;

  typedef struct packed {
    request_t       rq;
    bit             typed;
    tfr_pkg::rgba_t color;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = '0;
  logic [3:0]  texel_format = '0;
  logic [15:0] texel = '0;
  logic [7:0]  palette_index = '0;
  logic [23:0] palette_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;

  tfr_pkg::rgba_t pending_colors[$];
  directed_row_t  directed_rows[$];
  logic [23:0]    palette_copy[PAL_ENTRIES];
  bit             palette_loaded;
  bit             no_idle;
  int unsigned    hold_cycles;
  int unsigned    mismatches;
  int unsigned    colors_checked;
  int unsigned    converts_sent;
  int unsigned    writes_sent;
  int unsigned    invalidates_sent;
  int unsigned    requests_sent;

  texel_format_to_rgba8_top #(
    .PALETTE_ENTRIES(PAL_ENTRIES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .texel_format (texel_format),
    .texel        (texel),
    .palette_index(palette_index),
    .palette_value(palette_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("texel_format_to_rgba8_top_test: done, errors");
    $finish;
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // truncating x*255/max
  function automatic logic [7:0] scale_field(int unsigned x, int unsigned maxv);
    return 8'((x * 255) / maxv);
  endfunction

  function automatic logic [23:0] palette_rgb(logic [7:0] idx);
    if (!palette_loaded) return tfr_pkg::MAGENTA_RGB;
    if (int'(idx) >= PAL_ENTRIES) return '0;
    return palette_copy[idx];
  endfunction

  // Updates the palette copy; returns 1 when the request yields a color.
  function automatic bit predict_color(request_t rq, output tfr_pkg::rgba_t c);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] t;
    logic [23:0] rgb;
    t  = rq.texel;
    lo = t[7:0];
    hi = t[15:8];
    c  = '{8'hFF, 8'h00, 8'hFF, 8'hFF};
    case (rq.kind)
      tfr_pkg::KIND_WRITE: begin
        if (int'(rq.pidx) < PAL_ENTRIES) begin
          palette_copy[rq.pidx] = rq.pval;
          if (int'(rq.pidx) == PAL_ENTRIES - 1) palette_loaded = 1'b1;
        end
        return 1'b0;
      end
      tfr_pkg::KIND_INVALIDATE: begin
        palette_loaded = 1'b0;
        return 1'b0;
      end
      tfr_pkg::KIND_CONVERT: ;
      default: return 1'b0;
    endcase
    // {n, n} is n*17 for a 4-bit field
    case (rq.fmt)
      tfr_pkg::FMT_RGB332:
        c = '{scale_field(lo[7:5], 7), scale_field(lo[4:2], 7), scale_field(lo[1:0], 3),
              8'hFF};
      tfr_pkg::FMT_A8:   c = '{8'hFF, 8'hFF, 8'hFF, lo};
      tfr_pkg::FMT_I8:   c = '{lo, lo, lo, 8'hFF};
      tfr_pkg::FMT_AI44: c = '{{lo[3:0], lo[3:0]}, {lo[3:0], lo[3:0]}, {lo[3:0], lo[3:0]},
                               {lo[7:4], lo[7:4]}};
      tfr_pkg::FMT_P8: begin
        rgb = palette_rgb(lo);
        c = '{rgb[23:16], rgb[15:8], rgb[7:0], 8'hFF};
      end
      tfr_pkg::FMT_ARGB8332:
        c = '{scale_field(t[7:5], 7), scale_field(t[4:2], 7), scale_field(t[1:0], 3), hi};
      tfr_pkg::FMT_RGB565:
        c = '{scale_field(t[15:11], 31), scale_field(t[10:5], 63), scale_field(t[4:0], 31),
              8'hFF};
      tfr_pkg::FMT_ARGB1555:
        c = '{scale_field(t[14:10], 31), scale_field(t[9:5], 31), scale_field(t[4:0], 31),
              t[15] ? 8'hFF : 8'h00};
      tfr_pkg::FMT_ARGB4444:
        c = '{{t[11:8], t[11:8]}, {t[7:4], t[7:4]}, {t[3:0], t[3:0]}, {t[15:12], t[15:12]}};
      tfr_pkg::FMT_AI88: c = '{lo, lo, lo, hi};
      tfr_pkg::FMT_AP88: begin
        rgb = palette_rgb(lo);
        c = '{rgb[23:16], rgb[15:8], rgb[7:0], hi};
      end
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic request_t random_request(logic [1:0] k);
    request_t rq;
    rq.kind  = k;
    rq.fmt   = 4'($urandom_range(0, 15));
    rq.texel = 16'($urandom);
    rq.pidx  = 8'($urandom);
    rq.pval  = 24'($urandom);
    // lean on the palette formats, they carry the state
    if (k == tfr_pkg::KIND_CONVERT && $urandom_range(0, 9) < 4)
      rq.fmt = $urandom_range(0, 1) ? tfr_pkg::FMT_P8 : tfr_pkg::FMT_AP88;
    return rq;
  endfunction

  task automatic add_row(logic [1:0] k, logic [3:0] f, logic [15:0] t, logic [7:0] pi,
                         logic [23:0] pv, bit typed, tfr_pkg::rgba_t color);
    directed_row_t row;
    row.rq    = '{k, f, t, pi, pv};
    row.typed = typed;
    row.color = color;
    directed_rows.push_back(row);
  endtask

  task automatic send_request(request_t rq, bit typed, tfr_pkg::rgba_t typed_color);
    tfr_pkg::rgba_t c;
    int unsigned    gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= rq.kind;
    texel_format  <= rq.fmt;
    texel         <= rq.texel;
    palette_index <= rq.pidx;
    palette_value <= rq.pval;
    do @(posedge clk); while (!in_ready);
    if (predict_color(rq, c)) pending_colors.push_back(typed ? typed_color : c);
    case (rq.kind)
      tfr_pkg::KIND_CONVERT:    converts_sent++;
      tfr_pkg::KIND_WRITE:      writes_sent++;
      tfr_pkg::KIND_INVALIDATE: invalidates_sent++;
      default: ;
    endcase
    if (rq.kind != KIND_UNUSED) requests_sent++;
  endtask

  task automatic wait_for_colors();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_colors.size() != 0);
  endtask

  task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", name, want, got);
      mismatches++;
    end
  endtask

  // color sink
  initial begin
    int unsigned    stall;
    tfr_pkg::rgba_t want;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = idle_draw();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_colors.size() == 0) begin
        $error("color %02h %02h %02h %02h with no request waiting", red, green, blue, alpha);
        mismatches++;
      end else begin
        want = pending_colors.pop_front();
        check_channel("red", want.r, red);
        check_channel("green", want.g, green);
        check_channel("blue", want.b, blue);
        check_channel("alpha", want.a, alpha);
        colors_checked++;
      end
    end
  end

  initial begin
    request_t    rq;
    int unsigned seg;
    int unsigned len;
    int unsigned directed_count;
    foreach (palette_copy[i]) palette_copy[i] = '0;
    palette_loaded = 1'b0;

    // palette not loaded yet: magenta, AP88 keeps its alpha
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_P8, 16'h0012, 8'h00, 24'h0, 1'b1, 32'hFF00FFFF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_AP88, 16'h5A34, 8'h00, 24'h0, 1'b1,
            32'hFF00FF5A);
    // unsupported formats
    add_row(tfr_pkg::KIND_CONVERT, 4'd11, 16'h1234, 8'h00, 24'h0, 1'b1, 32'hFF00FFFF);
    add_row(tfr_pkg::KIND_CONVERT, 4'd15, 16'hFFFF, 8'hFF, 24'hFFFFFF, 1'b1, 32'hFF00FFFF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_RGB332, 16'h0000, 8'h00, 24'h0, 1'b1,
            32'h000000FF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_RGB332, 16'hFFFF, 8'h00, 24'h0, 1'b1,
            32'hFFFFFFFF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_A8, 16'h0080, 8'h00, 24'h0, 1'b1, 32'hFFFFFF80);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_I8, 16'h00AB, 8'h00, 24'h0, 1'b1, 32'hABABABFF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_AI44, 16'h00F0, 8'h00, 24'h0, 1'b1,
            32'h000000FF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_ARGB8332, 16'h7F6D, 8'h00, 24'h0, 1'b0,
            32'h0);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_RGB565, 16'hFFFF, 8'h00, 24'h0, 1'b1,
            32'hFFFFFFFF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_RGB565, 16'h0000, 8'h00, 24'h0, 1'b1,
            32'h000000FF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_RGB565, 16'h8410, 8'h00, 24'h0, 1'b0,
            32'h0);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_ARGB1555, 16'h8000, 8'h00, 24'h0, 1'b1,
            32'h000000FF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_ARGB1555, 16'h7FFF, 8'h00, 24'h0, 1'b1,
            32'hFFFFFF00);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_ARGB4444, 16'h1234, 8'h00, 24'h0, 1'b1,
            32'h22334411);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_AI88, 16'hC3A5, 8'h00, 24'h0, 1'b1,
            32'hA5A5A5C3);
    // unused kind code: no color
    add_row(KIND_UNUSED, tfr_pkg::FMT_P8, 16'hFFFF, 8'hFF, 24'hFFFFFF, 1'b0, 32'h0);
    add_row(tfr_pkg::KIND_WRITE, tfr_pkg::FMT_RGB332, 16'h0000, 8'h07, 24'h123456, 1'b0,
            32'h0);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_P8, 16'h0007, 8'h00, 24'h0, 1'b1, 32'hFF00FFFF);
    // last entry completes the palette
    add_row(tfr_pkg::KIND_WRITE, tfr_pkg::FMT_RGB332, 16'h0000, 8'hFF, 24'hABCDEF, 1'b0,
            32'h0);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_P8, 16'h0007, 8'h00, 24'h0, 1'b1, 32'h123456FF);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_AP88, 16'h80FF, 8'h00, 24'h0, 1'b1,
            32'hABCDEF80);
    // entry never written reads black
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_P8, 16'h0003, 8'h00, 24'h0, 1'b1, 32'h000000FF);
    add_row(tfr_pkg::KIND_INVALIDATE, tfr_pkg::FMT_RGB332, 16'h0000, 8'h00, 24'h0, 1'b0,
            32'h0);
    add_row(tfr_pkg::KIND_CONVERT, tfr_pkg::FMT_AP88, 16'h0007, 8'h00, 24'h0, 1'b1,
            32'hFF00FF00);
    directed_count = directed_rows.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].color);

    // full palette load with random colors, back to back
    no_idle = 1'b1;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      rq = random_request(tfr_pkg::KIND_WRITE);
      rq.pidx = 8'(i);
      send_request(rq, 1'b0, '0);
    end

    // sink holds off while converts keep coming, then the source drains
    hold_cycles = LONG_HOLD;
    repeat (30) send_request(random_request(tfr_pkg::KIND_CONVERT), 1'b0, '0);
    wait_for_colors();

    while (requests_sent < RANDOM_REQUESTS + directed_count) begin
      no_idle = ($urandom_range(0, 3) == 0);
      len = $urandom_range(4, 24);
      seg = $urandom_range(0, 9);
      case (seg)
        5: repeat (len) send_request(random_request(tfr_pkg::KIND_WRITE), 1'b0, '0);
        6: begin
          // partial reload ending on the last entry
          repeat (len / 4) send_request(random_request(tfr_pkg::KIND_WRITE), 1'b0, '0);
          rq = random_request(tfr_pkg::KIND_WRITE);
          rq.pidx = 8'(PAL_ENTRIES - 1);
          send_request(rq, 1'b0, '0);
        end
        7: send_request(random_request(tfr_pkg::KIND_INVALIDATE), 1'b0, '0);
        8: repeat (len) send_request(random_request(2'($urandom_range(0, 3))), 1'b0, '0);
        9: wait_for_colors();
        default: repeat (len) send_request(random_request(tfr_pkg::KIND_CONVERT), 1'b0, '0);
      endcase
    end

    wait_for_colors();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d converts, %0d palette writes, %0d invalidates.",
             requests_sent, converts_sent, writes_sent, invalidates_sent);
    $display("Checked %0d colors, %0d mismatches.", colors_checked, mismatches);
    if (mismatches == 0) begin
      $display("texel_format_to_rgba8_top_test: done, clean");
    end else begin
      $display("texel_format_to_rgba8_top_test: done, errors");
    end
    $finish;
  end

endmodule
